### design/owm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the one-wire bus master
// Request and result payloads, configuration set, sequencer state.
// ----------------------------------------------------------------------------
package owm_pkg;

	localparam int unsigned TW = 12;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_RESET = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		REG_RESET_LOW   = 3'd0,
		REG_RESET_REL   = 3'd1,
		REG_PRES_WAIT   = 3'd2,
		REG_PRES_END    = 3'd3,
		REG_SHORT_LOW   = 3'd4,
		REG_LONG_SLOT   = 3'd5,
		REG_READ_SAMPLE = 3'd6,
		REG_READ_RECOV  = 3'd7
	} reg_index_t;

	typedef enum logic [9:0] {
		PH_IDLE      = 10'b00_0000_0001,
		PH_RST_LOW   = 10'b00_0000_0010,
		PH_RST_REL   = 10'b00_0000_0100,
		PH_PRES_LOW  = 10'b00_0000_1000,
		PH_PRES_HIGH = 10'b00_0001_0000,
		PH_WR_LOW    = 10'b00_0010_0000,
		PH_WR_HIGH   = 10'b00_0100_0000,
		PH_RD_LOW    = 10'b00_1000_0000,
		PH_RD_WAIT   = 10'b01_0000_0000,
		PH_RD_REC    = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       line_in;
	} req_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       device_present;
		logic [7:0] read_data;
		logic       rejected;
	} rsp_t;

	typedef struct packed {
		logic [TW-1:0] reset_low_us;
		logic [TW-1:0] reset_release_us;
		logic [TW-1:0] presence_wait_limit;
		logic [TW-1:0] presence_end_limit;
		logic [TW-1:0] short_low_us;
		logic [TW-1:0] long_slot_us;
		logic [TW-1:0] read_sample_us;
		logic [TW-1:0] read_recovery_us;
	} cfg_t;

	typedef struct packed {
		phase_t        phase;
		logic [TW-1:0] time_count;
		logic [2:0]    bit_index;
		logic [7:0]    shift_byte;
		logic          presence_flag;
		logic [7:0]    read_result;
	} seq_state_t;

endpackage

### design/owm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_cfg: timing register file
// Eight 12-bit timing and limit registers, written through a plain port.
// ----------------------------------------------------------------------------
module owm_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [11:0]         cfg_data,
	output owm_pkg::cfg_t       cfg
);
	import owm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us        <= 12'd750;
			cfg_q.reset_release_us    <= 12'd15;
			cfg_q.presence_wait_limit <= 12'd200;
			cfg_q.presence_end_limit  <= 12'd240;
			cfg_q.short_low_us        <= 12'd2;
			cfg_q.long_slot_us        <= 12'd60;
			cfg_q.read_sample_us      <= 12'd12;
			cfg_q.read_recovery_us    <= 12'd50;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_RESET_LOW:   cfg_q.reset_low_us        <= cfg_data;
				REG_RESET_REL:   cfg_q.reset_release_us    <= cfg_data;
				REG_PRES_WAIT:   cfg_q.presence_wait_limit <= cfg_data;
				REG_PRES_END:    cfg_q.presence_end_limit  <= cfg_data;
				REG_SHORT_LOW:   cfg_q.short_low_us        <= cfg_data;
				REG_LONG_SLOT:   cfg_q.long_slot_us        <= cfg_data;
				REG_READ_SAMPLE: cfg_q.read_sample_us      <= cfg_data;
				REG_READ_RECOV:  cfg_q.read_recovery_us    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/owm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_step: one-microsecond sequencer step
// Next bus state and result for one request, from the current state.
// ----------------------------------------------------------------------------
module owm_step (
	input  owm_pkg::seq_state_t cur,
	input  owm_pkg::req_t       req,
	input  owm_pkg::cfg_t       cfg,
	output owm_pkg::seq_state_t nxt,
	output owm_pkg::rsp_t       rsp
);
	import owm_pkg::*;

	function automatic logic [TW:0] timed(input logic [TW-1:0] tc, input logic [TW-1:0] len);
		logic [TW-1:0] inc;
		inc = tc + {{(TW-1){1'b0}}, 1'b1};
		if (inc >= len) return {1'b1, {TW{1'b0}}};
		return {1'b0, inc};
	endfunction

	seq_state_t s;
	logic       drive;
	logic       done;
	logic       rej;
	logic [TW:0] t;

	always_comb begin
		s     = cur;
		drive = 1'b0;
		done  = 1'b0;
		rej   = 1'b0;
		t     = '0;

		if (opcode_t'(req.opcode) != OP_TICK) begin
			if (cur.phase != PH_IDLE) begin
				rej = 1'b1;
			end else begin
				s.time_count = '0;
				s.bit_index  = '0;
				case (opcode_t'(req.opcode))
					OP_RESET: s.phase = PH_RST_LOW;
					OP_WRITE: begin
						s.phase      = PH_WR_LOW;
						s.shift_byte = req.data_byte;
					end
					default: begin
						s.phase      = PH_RD_LOW;
						s.shift_byte = '0;
					end
				endcase
			end
		end

		case (s.phase)
			PH_IDLE: begin
			end
			PH_RST_LOW: begin
				drive        = 1'b1;
				t            = timed(s.time_count, cfg.reset_low_us);
				s.time_count = t[TW-1:0];
				if (t[TW]) s.phase = PH_RST_REL;
			end
			PH_RST_REL: begin
				t            = timed(s.time_count, cfg.reset_release_us);
				s.time_count = t[TW-1:0];
				if (t[TW]) s.phase = PH_PRES_LOW;
			end
			PH_PRES_LOW: begin
				if (!req.line_in) begin
					s.time_count = '0;
					s.phase      = PH_PRES_HIGH;
				end else begin
					t            = timed(s.time_count, cfg.presence_wait_limit);
					s.time_count = t[TW-1:0];
					if (t[TW]) begin
						s.presence_flag = 1'b0;
						s.phase         = PH_IDLE;
						done            = 1'b1;
					end
				end
			end
			PH_PRES_HIGH: begin
				if (req.line_in) begin
					s.time_count    = '0;
					s.presence_flag = 1'b1;
					s.phase         = PH_IDLE;
					done            = 1'b1;
				end else begin
					t            = timed(s.time_count, cfg.presence_end_limit);
					s.time_count = t[TW-1:0];
					if (t[TW]) begin
						s.presence_flag = 1'b0;
						s.phase         = PH_IDLE;
						done            = 1'b1;
					end
				end
			end
			PH_WR_LOW: begin
				drive        = 1'b1;
				t            = timed(s.time_count,
					s.shift_byte[0] ? cfg.short_low_us : cfg.long_slot_us);
				s.time_count = t[TW-1:0];
				if (t[TW]) s.phase = PH_WR_HIGH;
			end
			PH_WR_HIGH: begin
				t            = timed(s.time_count,
					s.shift_byte[0] ? cfg.long_slot_us : cfg.short_low_us);
				s.time_count = t[TW-1:0];
				if (t[TW]) begin
					s.shift_byte = {1'b0, s.shift_byte[7:1]};
					if (s.bit_index == 3'd7) begin
						s.bit_index = '0;
						s.phase     = PH_IDLE;
						done        = 1'b1;
					end else begin
						s.bit_index = s.bit_index + 3'd1;
						s.phase     = PH_WR_LOW;
					end
				end
			end
			PH_RD_LOW: begin
				drive        = 1'b1;
				t            = timed(s.time_count, cfg.short_low_us);
				s.time_count = t[TW-1:0];
				if (t[TW]) s.phase = PH_RD_WAIT;
			end
			PH_RD_WAIT: begin
				t            = timed(s.time_count, cfg.read_sample_us);
				s.time_count = t[TW-1:0];
				if (t[TW]) s.phase = PH_RD_REC;
			end
			PH_RD_REC: begin
				if (s.time_count == '0) s.shift_byte = {req.line_in, s.shift_byte[7:1]};
				t            = timed(s.time_count, cfg.read_recovery_us);
				s.time_count = t[TW-1:0];
				if (t[TW]) begin
					if (s.bit_index == 3'd7) begin
						s.bit_index   = '0;
						s.read_result = s.shift_byte;
						s.phase       = PH_IDLE;
						done          = 1'b1;
					end else begin
						s.bit_index = s.bit_index + 3'd1;
						s.phase     = PH_RD_LOW;
					end
				end
			end
			default: s.phase = PH_IDLE;
		endcase
	end

	assign nxt                = s;
	assign rsp.drive_low      = drive;
	assign rsp.busy_res       = (s.phase != PH_IDLE);
	assign rsp.done_res       = done;
	assign rsp.device_present = s.presence_flag;
	assign rsp.read_data      = s.read_result;
	assign rsp.rejected       = rej;

endmodule

### design/one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master: one-wire bus master, one request per microsecond
// Reset with presence check, byte write and byte read, LSB first.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | req_valid, req_stall | req   (opcode, data_byte, line_in)
//  result   | rsp_valid, rsp_stall | rsp   (drive_low .. rejected)
//  config   | cfg_we               | cfg_index, cfg_data
//
//  One request per cycle unless a stalled result holds the stages; one result per request.
//  The request register feeds the sequencer step, which loads the result
//  register and the bus state in the same cycle.
//  Reset puts the sequencer idle and the timing registers at their defaults.
//  A stalled result holds both stages; req_stall follows rsp_stall then.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  owm_pkg::req_t   req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output owm_pkg::rsp_t   rsp,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [11:0]     cfg_data
);
	import owm_pkg::*;

	logic       advance;
	logic       req_valid_s1;
	req_t       req_s1;
	seq_state_t state_q;
	seq_state_t state_nxt;
	rsp_t       rsp_nxt;
	rsp_t       rsp_s2;
	logic       rsp_valid_s2;
	cfg_t       cfg;

	assign advance   = !(rsp_valid_s2 && rsp_stall);
	assign req_stall = !advance;

	owm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owm_step u_step (
		.cur (state_q),
		.req (req_s1),
		.cfg (cfg),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			req_valid_s1 <= req_valid;
			rsp_valid_s2 <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			req_s1 <= req;
			if (req_valid_s1) rsp_s2 <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.time_count    <= '0;
			state_q.bit_index     <= '0;
			state_q.shift_byte    <= '0;
			state_q.presence_flag <= 1'b0;
			state_q.read_result   <= '0;
		end else if (advance && req_valid_s1) begin
			state_q <= state_nxt;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_valid_s1) |=> rsp_valid_s2)
		else $error("request in stage one produced no result");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_s2 && rsp_s2.drive_low) |-> rsp_s2.busy_res)
		else $error("line driven low with no operation pending");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_s2 && rsp_s2.done_res) |-> !rsp_s2.busy_res)
		else $error("operation finished but still busy");

	a_idle_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_IDLE) |-> (state_q.bit_index == 3'd0))
		else $error("bit index left nonzero when idle");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the one-wire bus master
// Builds microsecond request streams in batches, one timing setting per batch.
// Bus line levels are scripted from a shadow copy of the sequencer, so presence
// answers land early, late, on the limit or never. Every result is compared
// field by field with an in-bench prediction of the sequencer, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import owm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 8_000_000;

	typedef logic [11:0] timing_t [8];

	typedef struct packed {
		phase_t      phase;
		logic [11:0] tcount;
		logic [2:0]  bitno;
		logic [7:0]  shreg;
		logic        present;
		logic [7:0]  rdbyte;
	} bus_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	timing_t     chk_timing = '{12'd750, 12'd15, 12'd200, 12'd240, 12'd2, 12'd60, 12'd12, 12'd50};
	timing_t     gen_timing = '{12'd750, 12'd15, 12'd200, 12'd240, 12'd2, 12'd60, 12'd12, 12'd50};
	bus_state_t  chk_st;
	bus_state_t  gen_st;

	req_t        tick_queue[$];
	rsp_t        rsp_due[$];
	rsp_t        want;
	int unsigned queued = 0;
	int unsigned accepted = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int          hi_plan = 0;
	int          lo_plan = 0;
	bit          noisy = 1'b0;
	int          gap = 0;
	int          hold = 0;
	bit          drv_calm = 1'b0;
	bit          sink_calm = 1'b0;

	one_wire_bus_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// advance a timed phase; true once its length is reached (zero acts as one)
	function automatic bit elapse(inout bus_state_t s, input logic [11:0] len);
		s.tcount = s.tcount + 12'd1;
		if (s.tcount >= len) begin
			s.tcount = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic rsp_t bus_tick(inout bus_state_t s, input timing_t t, input req_t r);
		rsp_t        o;
		logic [11:0] len;
		o = '0;
		if (r.opcode != OP_TICK) begin
			if (s.phase != PH_IDLE) begin
				o.rejected = 1'b1;
			end else begin
				s.tcount = '0;
				s.bitno = '0;
				case (opcode_t'(r.opcode))
					OP_RESET: s.phase = PH_RST_LOW;
					OP_WRITE: begin
						s.phase = PH_WR_LOW;
						s.shreg = r.data_byte;
					end
					default: begin
						s.phase = PH_RD_LOW;
						s.shreg = '0;
					end
				endcase
			end
		end
		case (s.phase)
			PH_RST_LOW: begin
				o.drive_low = 1'b1;
				if (elapse(s, t[REG_RESET_LOW])) s.phase = PH_RST_REL;
			end
			PH_RST_REL: begin
				if (elapse(s, t[REG_RESET_REL])) s.phase = PH_PRES_LOW;
			end
			PH_PRES_LOW: begin
				if (!r.line_in) begin
					s.tcount = '0;
					s.phase = PH_PRES_HIGH;
				end else if (elapse(s, t[REG_PRES_WAIT])) begin
					s.present = 1'b0;
					s.phase = PH_IDLE;
					o.done_res = 1'b1;
				end
			end
			PH_PRES_HIGH: begin
				if (r.line_in) begin
					s.tcount = '0;
					s.present = 1'b1;
					s.phase = PH_IDLE;
					o.done_res = 1'b1;
				end else if (elapse(s, t[REG_PRES_END])) begin
					s.present = 1'b0;
					s.phase = PH_IDLE;
					o.done_res = 1'b1;
				end
			end
			PH_WR_LOW: begin
				o.drive_low = 1'b1;
				len = s.shreg[0] ? t[REG_SHORT_LOW] : t[REG_LONG_SLOT];
				if (elapse(s, len)) s.phase = PH_WR_HIGH;
			end
			PH_WR_HIGH: begin
				len = s.shreg[0] ? t[REG_LONG_SLOT] : t[REG_SHORT_LOW];
				if (elapse(s, len)) begin
					s.shreg = s.shreg >> 1;
					if (s.bitno == 3'd7) begin
						s.bitno = '0;
						s.phase = PH_IDLE;
						o.done_res = 1'b1;
					end else begin
						s.bitno = s.bitno + 3'd1;
						s.phase = PH_WR_LOW;
					end
				end
			end
			PH_RD_LOW: begin
				o.drive_low = 1'b1;
				if (elapse(s, t[REG_SHORT_LOW])) s.phase = PH_RD_WAIT;
			end
			PH_RD_WAIT: begin
				if (elapse(s, t[REG_READ_SAMPLE])) s.phase = PH_RD_REC;
			end
			PH_RD_REC: begin
				if (s.tcount == '0) s.shreg = {r.line_in, s.shreg[7:1]};
				if (elapse(s, t[REG_READ_RECOV])) begin
					if (s.bitno == 3'd7) begin
						s.bitno = '0;
						s.rdbyte = s.shreg;
						s.phase = PH_IDLE;
						o.done_res = 1'b1;
					end else begin
						s.bitno = s.bitno + 3'd1;
						s.phase = PH_RD_LOW;
					end
				end
			end
			default: s.phase = PH_IDLE;
		endcase
		o.busy_res = (s.phase != PH_IDLE);
		o.device_present = s.present;
		o.read_data = s.rdbyte;
		return o;
	endfunction

	// scripted bus level: high for hi_plan presence polls, then low for lo_plan polls
	function automatic logic next_line();
		if (noisy && $urandom_range(0, 31) == 0) return 1'($urandom_range(0, 1));
		case (gen_st.phase)
			PH_PRES_LOW:  return (gen_st.tcount < hi_plan) ? 1'b1 : 1'b0;
			PH_PRES_HIGH: return (gen_st.tcount < lo_plan) ? 1'b0 : 1'b1;
			default:      return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic int poll_plan(logic [11:0] lim);
		int eff;
		eff = (lim == '0) ? 1 : int'(lim);
		case ($urandom_range(0, 3))
			0:       return eff;
			1:       return eff - 1;
			default: return $urandom_range(0, eff - 1);
		endcase
	endfunction

	function automatic logic [11:0] rand_timing();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) return '0;
		if (pick < 4) return 12'($urandom_range(7, 20));
		return 12'($urandom_range(1, 6));
	endfunction

	task automatic emit(opcode_t op, logic [7:0] data);
		req_t r;
		r.opcode = op;
		r.data_byte = data;
		r.line_in = next_line();
		tick_queue.push_back(r);
		void'(bus_tick(gen_st, gen_timing, r));
		queued++;
	endtask

	task automatic idle_ticks(int n);
		repeat (n) emit(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	// launch one command and keep ticking, with meddle_pct percent stray commands, until the sequencer is idle again
	task automatic run_op(opcode_t op, logic [7:0] data, int hi, int lo, int meddle_pct);
		hi_plan = hi;
		lo_plan = lo;
		emit(op, data);
		while (gen_st.phase != PH_IDLE) begin
			if ($urandom_range(1, 100) <= meddle_pct)
				emit(opcode_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
			else
				emit(OP_TICK, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic set_reg(reg_index_t idx, logic [11:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		chk_timing[idx] = val;
		gen_timing[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(logic [11:0] val);
		for (int k = 0; k < 8; k++) set_reg(reg_index_t'(k), val);
	endtask

	task automatic drain();
		while (accepted != queued || rsp_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver: one request per handshake, random gap after each
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap <= 0;
		end else begin
			if ($urandom_range(0, 99) == 0) drv_calm <= !drv_calm;
			if (req_valid && !req_stall) begin
				rsp_due.push_back(bus_tick(chk_st, chk_timing, req));
				accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (gap != 0) begin
					gap <= gap - 1;
					req_valid <= 1'b0;
				end else if (tick_queue.size() != 0) begin
					req <= tick_queue.pop_front();
					req_valid <= 1'b1;
					gap <= drv_calm ? 0 : $urandom_range(0, 5);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare in order, stall for a random count after each result
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold = 0;
		end else begin
			if ($urandom_range(0, 99) == 0) sink_calm <= !sink_calm;
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %h", $time, rsp);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.drive_low !== want.drive_low) begin
						errors++;
						if (errors < 40) $display("%0t: drive_low expected %0b got %0b",
							$time, want.drive_low, rsp.drive_low);
					end
					if (rsp.busy_res !== want.busy_res) begin
						errors++;
						if (errors < 40) $display("%0t: busy_res expected %0b got %0b",
							$time, want.busy_res, rsp.busy_res);
					end
					if (rsp.done_res !== want.done_res) begin
						errors++;
						if (errors < 40) $display("%0t: done_res expected %0b got %0b",
							$time, want.done_res, rsp.done_res);
					end
					if (rsp.device_present !== want.device_present) begin
						errors++;
						if (errors < 40) $display("%0t: device_present expected %0b got %0b",
							$time, want.device_present, rsp.device_present);
					end
					if (rsp.read_data !== want.read_data) begin
						errors++;
						if (errors < 40) $display("%0t: read_data expected %h got %h",
							$time, want.read_data, rsp.read_data);
					end
					if (rsp.rejected !== want.rejected) begin
						errors++;
						if (errors < 40) $display("%0t: rejected expected %0b got %0b",
							$time, want.rejected, rsp.rejected);
					end
				end
				hold = sink_calm ? 0 : $urandom_range(0, 5);
				rsp_stall <= (hold != 0);
			end else if (hold != 0) begin
				hold = hold - 1;
				rsp_stall <= (hold != 0);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("one_wire_bus_master: mismatch");
			$finish;
		end
	end

	initial begin
		chk_st = '0;
		chk_st.phase = PH_IDLE;
		gen_st = chk_st;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// power-up timing
		idle_ticks(3);
		run_op(OP_RESET, 8'h00, 3, 5, 0);
		drain();

		// zero timing behaves like one
		set_all(12'd0);
		idle_ticks(2);
		run_op(OP_RESET, 8'hFF, 0, 0, 0);
		run_op(OP_RESET, 8'h00, 1, 0, 0);
		run_op(OP_RESET, 8'h00, 0, 1, 30);
		run_op(OP_WRITE, 8'h00, 0, 0, 0);
		run_op(OP_WRITE, 8'hFF, 0, 0, 30);
		run_op(OP_READ, 8'h55, 0, 0, 30);
		idle_ticks(2);
		drain();

		// presence on the last allowed poll, and one past it
		set_all(12'd3);
		run_op(OP_RESET, 8'h00, 2, 2, 0);
		run_op(OP_RESET, 8'h00, 3, 0, 0);
		run_op(OP_RESET, 8'h00, 0, 3, 0);
		run_op(OP_WRITE, 8'h80, 0, 0, 20);
		run_op(OP_READ, 8'h00, 0, 0, 0);
		drain();

		noisy = 1'b1;
		while (queued < 1250) begin
			for (int k = 0; k < 8; k++) set_reg(reg_index_t'(k), rand_timing());
			repeat ($urandom_range(4, 10)) begin
				if ($urandom_range(0, 3) == 0) idle_ticks($urandom_range(1, 4));
				run_op(opcode_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
					poll_plan(gen_timing[REG_PRES_WAIT]),
					poll_plan(gen_timing[REG_PRES_END]), 5);
			end
			drain();
		end

		if (errors == 0)
			$display("one_wire_bus_master: match");
		else
			$display("one_wire_bus_master: mismatch");
		$finish;
	end

endmodule
